// File: rtl/crt_pkg.sv
`timescale 1ns / 1ps

package crt_pkg;

   // Field widths
   localparam int SynWidth  = 20;
   localparam int DataWidth = 32;
   localparam int RtWidth   = 5;

   // Key extraction mask (CRm, CRn, Opc1, Opc2)
   localparam logic [SynWidth-1:0] KeyMask = 20'hffc1e;

   // Read-only ID keys
   localparam logic [SynWidth-1:0] KeyMainId     = 20'h00000;
   localparam logic [SynWidth-1:0] KeyMpId       = 20'ha0000;
   localparam logic [SynWidth-1:0] KeyCacheType  = 20'h20000;
   localparam logic [SynWidth-1:0] KeyAuxCtrlId  = 20'h20002;

   // Write-only maintenance keys
   localparam logic [SynWidth-1:0] KeyIcacheInv  = 20'h01c0a;
   localparam logic [SynWidth-1:0] KeyTlbInv     = 20'h0200e;
   localparam logic [SynWidth-1:0] KeyBpInv      = 20'hc1c0a;
   localparam logic [SynWidth-1:0] KeyTlbInvAll  = 20'h24000;
   localparam logic [SynWidth-1:0] KeyDsb        = 20'h81c14;
   localparam logic [SynWidth-1:0] KeyIsb        = 20'h81c0a;
   localparam logic [SynWidth-1:0] KeyDmb        = 20'ha1c14;
   localparam logic [SynWidth-1:0] KeyCleanDmb   = 20'h01c1c;
   localparam logic [SynWidth-1:0] KeyInvIsbDsb  = 20'h01c0e;

   // Read/write register keys
   localparam logic [SynWidth-1:0] KeyControl    = 20'h00400;
   localparam logic [SynWidth-1:0] KeyDomain     = 20'h00c00;
   localparam logic [SynWidth-1:0] KeyTransCtrl  = 20'h40800;
   localparam logic [SynWidth-1:0] KeyTableBase  = 20'h00800;

   // Fixed ID values
   localparam logic [DataWidth-1:0] ValMainId    = 32'h410fb767;
   localparam logic [DataWidth-1:0] ValMpId      = 32'h80000f00;
   localparam logic [DataWidth-1:0] ValCacheType = 32'h1d152152;
   localparam logic [DataWidth-1:0] ValAuxCtrlId = 32'h00000001;

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_RO   = 2'd1,
      KIND_WO   = 2'd2,
      KIND_RW   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      BAR_NONE    = 3'd0,
      BAR_DSB     = 3'd1,
      BAR_ISB     = 3'd2,
      BAR_DMB     = 3'd3,
      BAR_ISB_DSB = 3'd4
   } barrier_type;

   typedef enum logic [1:0] {
      FAULT_OK      = 2'd0,
      FAULT_DIR     = 2'd1,
      FAULT_UNKNOWN = 2'd2
   } fault_type;

   typedef enum logic [1:0] {
      SEL_CONTROL    = 2'd0,
      SEL_DOMAIN     = 2'd1,
      SEL_TRANS_CTRL = 2'd2,
      SEL_TABLE_BASE = 2'd3
   } sysreg_type;

   // Decoded key
   typedef struct packed {
      kind_type              kind;
      logic [DataWidth-1:0]  fixed;
      barrier_type           bar;
      sysreg_type            sel;
   } decode_type;

   // Register file access from the result stage
   typedef struct packed {
      logic                  wr_en;
      sysreg_type            sel;
      logic [DataWidth-1:0]  wdata;
   } regs_req_type;

endpackage

// File: rtl/crt_decode.sv
`timescale 1ns / 1ps

module crt_decode
   import crt_pkg::*;
(
   input  logic [SynWidth-1:0] syndrome,
   output decode_type          dec
);

   logic [SynWidth-1:0] key;

   assign key = syndrome & KeyMask;

   // Key lookup
   always_comb begin
      dec = '{kind: KIND_NONE, fixed: '0, bar: BAR_NONE, sel: SEL_CONTROL};
      case (key)
         KeyMainId: begin
            dec.kind  = KIND_RO;
            dec.fixed = ValMainId;
         end
         KeyMpId: begin
            dec.kind  = KIND_RO;
            dec.fixed = ValMpId;
         end
         KeyCacheType: begin
            dec.kind  = KIND_RO;
            dec.fixed = ValCacheType;
         end
         KeyAuxCtrlId: begin
            dec.kind  = KIND_RO;
            dec.fixed = ValAuxCtrlId;
         end
         KeyIcacheInv, KeyTlbInv, KeyBpInv, KeyTlbInvAll: begin
            dec.kind = KIND_WO;
         end
         KeyDsb: begin
            dec.kind = KIND_WO;
            dec.bar  = BAR_DSB;
         end
         KeyIsb: begin
            dec.kind = KIND_WO;
            dec.bar  = BAR_ISB;
         end
         KeyDmb, KeyCleanDmb: begin
            dec.kind = KIND_WO;
            dec.bar  = BAR_DMB;
         end
         KeyInvIsbDsb: begin
            dec.kind = KIND_WO;
            dec.bar  = BAR_ISB_DSB;
         end
         KeyControl: begin
            dec.kind = KIND_RW;
            dec.sel  = SEL_CONTROL;
         end
         KeyDomain: begin
            dec.kind = KIND_RW;
            dec.sel  = SEL_DOMAIN;
         end
         KeyTransCtrl: begin
            dec.kind = KIND_RW;
            dec.sel  = SEL_TRANS_CTRL;
         end
         KeyTableBase: begin
            dec.kind = KIND_RW;
            dec.sel  = SEL_TABLE_BASE;
         end
         default: begin
            dec.kind = KIND_NONE;
         end
      endcase
   end

endmodule

// File: rtl/crt_sysregs.sv
`timescale 1ns / 1ps

module crt_sysregs
   import crt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  regs_req_type         req,
   output logic [DataWidth-1:0] rd_data
);

   logic [DataWidth-1:0] control_ff, control_in;
   logic [DataWidth-1:0] domain_ff, domain_in;
   logic [DataWidth-1:0] trans_ctrl_ff, trans_ctrl_in;
   logic [DataWidth-1:0] table_base_ff, table_base_in;

   // Write decode
   always_comb begin
      control_in    = control_ff;
      domain_in     = domain_ff;
      trans_ctrl_in = trans_ctrl_ff;
      table_base_in = table_base_ff;
      if (req.wr_en) begin
         case (req.sel)
            SEL_CONTROL:    control_in    = req.wdata;
            SEL_DOMAIN:     domain_in     = req.wdata;
            SEL_TRANS_CTRL: trans_ctrl_in = req.wdata;
            SEL_TABLE_BASE: table_base_in = req.wdata;
            default:        control_in    = control_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         control_ff    <= '0;
         domain_ff     <= '0;
         trans_ctrl_ff <= '0;
         table_base_ff <= '0;
      end else begin
         control_ff    <= control_in;
         domain_ff     <= domain_in;
         trans_ctrl_ff <= trans_ctrl_in;
         table_base_ff <= table_base_in;
      end
   end

   // Read mux
   always_comb begin
      case (req.sel)
         SEL_CONTROL:    rd_data = control_ff;
         SEL_DOMAIN:     rd_data = domain_ff;
         SEL_TRANS_CTRL: rd_data = trans_ctrl_ff;
         SEL_TABLE_BASE: rd_data = table_base_ff;
         default:        rd_data = control_ff;
      endcase
   end

endmodule

// File: rtl/coprocessor_register_trap_unit.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake             Payload
// req       in   req_tvalid/tready     tdata: syndrome_bits, write_data
// rsp       out  rsp_tvalid/tready     tdata: read_data .. fault_code
//
// Two register stages: an input register and a result register; decode,
// register file access and result forming sit between them.
// One beat per cycle sustained unless rsp stalls.
// Synchronous active-high reset clears both valid flags and the four
// system registers. A stalled rsp holds its beat; req keeps flowing while
// the result register drains or is empty.

module coprocessor_register_trap_unit
   import crt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [19:0] syndrome_bits, [51:20] write_data, [55:52] zero
   input  logic [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [31:0] read_data, [32] read_valid, [37:33] dest_reg, [38] sysreg_write,
   // [40:39] sysreg_select, [72:41] sysreg_value, [75:73] barrier_kind,
   // [77:76] fault_code, [79:78] zero
   output logic [79:0] rsp_tdata
);

   // Input stage
   logic                 in_valid_ff, in_valid_in;
   logic [SynWidth-1:0]  syn_ff;
   logic [DataWidth-1:0] wdata_ff;

   // Result stage
   logic                 out_valid_ff, out_valid_in;
   logic [DataWidth-1:0] read_data_ff, read_data_in;
   logic                 read_valid_ff, read_valid_in;
   logic [RtWidth-1:0]   dest_reg_ff, dest_reg_in;
   logic                 sysreg_write_ff, sysreg_write_in;
   sysreg_type           sysreg_select_ff, sysreg_select_in;
   logic [DataWidth-1:0] sysreg_value_ff, sysreg_value_in;
   barrier_type          barrier_kind_ff, barrier_kind_in;
   fault_type            fault_code_ff, fault_code_in;

   logic                 advance;
   logic                 req_beat;
   logic                 is_read;
   decode_type           dec;
   regs_req_type         regs_req;
   logic [DataWidth-1:0] regs_rd_data;

   // Pipeline control
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_beat   = req_tvalid && req_tready;
   assign is_read    = syn_ff[0];

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_beat) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Input register payload
   always_ff @(posedge clock) begin
      if (req_beat) begin
         syn_ff   <= req_tdata[SynWidth-1:0];
         wdata_ff <= req_tdata[SynWidth+DataWidth-1:SynWidth];
      end
   end

   crt_decode u_decode (
      .syndrome (syn_ff),
      .dec      (dec)
   );

   assign regs_req.wr_en = advance && (dec.kind == KIND_RW) && !is_read;
   assign regs_req.sel   = dec.sel;
   assign regs_req.wdata = wdata_ff;

   crt_sysregs u_sysregs (
      .clock   (clock),
      .reset   (reset),
      .req     (regs_req),
      .rd_data (regs_rd_data)
   );

   // Result forming
   always_comb begin
      read_data_in     = '0;
      read_valid_in    = 1'b0;
      dest_reg_in      = syn_ff[9:5];
      sysreg_write_in  = 1'b0;
      sysreg_select_in = SEL_CONTROL;
      sysreg_value_in  = '0;
      barrier_kind_in  = BAR_NONE;
      fault_code_in    = FAULT_OK;
      case (dec.kind)
         KIND_NONE: begin
            fault_code_in = FAULT_UNKNOWN;
         end
         KIND_RO: begin
            if (is_read) begin
               read_data_in  = dec.fixed;
               read_valid_in = 1'b1;
            end else begin
               fault_code_in = FAULT_DIR;
            end
         end
         KIND_WO: begin
            if (is_read) begin
               fault_code_in = FAULT_DIR;
            end else begin
               barrier_kind_in = dec.bar;
            end
         end
         KIND_RW: begin
            if (is_read) begin
               read_data_in  = regs_rd_data;
               read_valid_in = 1'b1;
            end else begin
               sysreg_write_in  = 1'b1;
               sysreg_select_in = dec.sel;
               sysreg_value_in  = wdata_ff;
            end
         end
         default: begin
            fault_code_in = FAULT_UNKNOWN;
         end
      endcase
   end

   // Result register payload
   always_ff @(posedge clock) begin
      if (advance) begin
         read_data_ff     <= read_data_in;
         read_valid_ff    <= read_valid_in;
         dest_reg_ff      <= dest_reg_in;
         sysreg_write_ff  <= sysreg_write_in;
         sysreg_select_ff <= sysreg_select_in;
         sysreg_value_ff  <= sysreg_value_in;
         barrier_kind_ff  <= barrier_kind_in;
         fault_code_ff    <= fault_code_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, fault_code_ff, barrier_kind_ff, sysreg_value_ff,
                        sysreg_select_ff, sysreg_write_ff, dest_reg_ff,
                        read_valid_ff, read_data_ff};

`ifndef SYNTHESIS
   // A faulting access must not read, write or signal a barrier
   a_fault_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (fault_code_ff != FAULT_OK) |->
         !read_valid_ff && !sysreg_write_ff && (barrier_kind_ff == BAR_NONE))
      else $error("faulting beat carries side effects");

   // A system register write is never a read and never a barrier
   a_write_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && sysreg_write_ff |->
         !read_valid_ff && (barrier_kind_ff == BAR_NONE) &&
         (fault_code_ff == FAULT_OK))
      else $error("sysreg write beat mixed with other effects");

   // Input only backs up while the result register is stalled
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> in_valid_ff && rsp_tvalid && !rsp_tready)
      else $error("req stalled without rsp backpressure");

   // A register file write happens only on a beat moving to the result stage
   a_write_advance: assert property (@(posedge clock) disable iff (reset)
      regs_req.wr_en |=> rsp_tvalid && sysreg_write_ff)
      else $error("register write without matching result beat");
`endif

endmodule
